// File: design/ihex_pkg.sv
package ihex_pkg;

	// Address width of the target memory
	localparam int unsigned ADDR_BITS = 16;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [7:0]           byte_t;

	// Character codes
	localparam byte_t CH_COLON   = 8'h3A;
	localparam byte_t CH_NEWLINE = 8'h0A;
	localparam byte_t CH_ZERO    = 8'h30;
	localparam byte_t CH_NINE    = 8'h39;
	localparam byte_t CH_UP_A    = 8'h41;
	localparam byte_t CH_UP_F    = 8'h46;
	localparam byte_t CH_LO_A    = 8'h61;
	localparam byte_t CH_LO_F    = 8'h66;

	// Input mode codes
	localparam logic MODE_CHAR  = 1'b0;
	localparam logic MODE_START = 1'b1;

	// Number of header nibbles: length, address, record type
	localparam logic [3:0] HDR_NIBBLES = 4'd8;
	localparam logic [3:0] LEN_END     = 4'd2;
	localparam logic [3:0] ADDR_END    = 4'd6;

	// Record type carrying data bytes
	localparam byte_t KIND_DATA = 8'h00;

	// Line phase, one-hot
	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_SKIP  = 4'b0010,
		PH_HEAD  = 4'b0100,
		PH_DATA  = 4'b1000
	} phase_t;

	// Decoded digit: bad flag and value
	typedef struct packed {
		logic       bad;
		logic [3:0] value;
	} digit_t;

	// One decoded data byte from the parser
	typedef struct packed {
		logic  valid;
		addr_t addr;
		byte_t data;
	} wr_beat_t;

	function automatic digit_t hex_digit(input byte_t ch);
		digit_t d;
		byte_t  off;
		d   = '{bad: 1'b0, value: 4'd0};
		off = 8'd0;
		if (ch inside {[CH_ZERO:CH_NINE]}) begin
			off     = ch - CH_ZERO;
			d.value = off[3:0];
		end else if (ch inside {[CH_UP_A:CH_UP_F]}) begin
			off     = ch - CH_UP_A + 8'd10;
			d.value = off[3:0];
		end else if (ch inside {[CH_LO_A:CH_LO_F]}) begin
			off     = ch - CH_LO_A + 8'd10;
			d.value = off[3:0];
		end else begin
			d.bad = 1'b1;
		end
		return d;
	endfunction

endpackage

// File: design/ihex_text_if.sv
interface ihex_text_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] char_code;

	modport source (output valid, output mode, output char_code, input ready);
	modport sink (input valid, input mode, input char_code, output ready);
endinterface

// File: design/ihex_wr_if.sv
interface ihex_wr_if;
	logic        valid;
	logic        ready;
	logic [15:0] write_addr;
	logic [7:0]  write_data;
	logic [15:0] lowest_addr;
	logic [15:0] highest_addr;

	modport source (output valid, output write_addr, output write_data,
		output lowest_addr, output highest_addr, input ready);
	modport sink (input valid, input write_addr, input write_data,
		input lowest_addr, input highest_addr, output ready);
endinterface

// File: design/ihex_parse.sv
// Line state machine: header decode and data byte pairing
module ihex_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             clear,
	input  ihex_pkg::byte_t  char_code,
	output ihex_pkg::wr_beat_t wr
);
	import ihex_pkg::*;

	phase_t     phase_q, phase_d;
	logic [3:0] cnt_q, cnt_d;
	byte_t      len_q, len_d;
	addr_t      raddr_q, raddr_d;
	byte_t      kind_q, kind_d;
	byte_t      idx_q, idx_d;
	logic [3:0] pend_q, pend_d;
	logic       half_q, half_d;
	logic       bad_q, bad_d;

	digit_t     dig;
	byte_t      kind_new;
	byte_t      idx_inc;
	logic       bad_pair;

	assign dig      = hex_digit(char_code);
	assign kind_new = {kind_q[3:0], dig.value};
	assign idx_inc  = idx_q + 8'd1;
	assign bad_pair = bad_q | dig.bad;

	// Next state for one character beat
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		len_d   = len_q;
		raddr_d = raddr_q;
		kind_d  = kind_q;
		idx_d   = idx_q;
		pend_d  = pend_q;
		half_d  = half_q;
		bad_d   = bad_q;
		wr      = '{valid: 1'b0, addr: raddr_q + addr_t'(idx_q),
			data: bad_pair ? 8'hFF : {pend_q, dig.value}};

		if (clear || char_code == CH_NEWLINE || phase_q == PH_START) begin
			// fresh line
			phase_d = PH_START;
			cnt_d   = 4'd0;
			len_d   = 8'd0;
			raddr_d = '0;
			kind_d  = 8'd0;
			idx_d   = 8'd0;
			pend_d  = 4'd0;
			half_d  = 1'b0;
			bad_d   = 1'b0;
			if (!clear && char_code != CH_NEWLINE)
				phase_d = (char_code == CH_COLON) ? PH_HEAD : PH_SKIP;
		end else begin
			case (phase_q)
				PH_SKIP: begin
				end
				PH_HEAD: begin
					if (dig.bad) begin
						phase_d = PH_SKIP;
					end else begin
						if (cnt_q < LEN_END)
							len_d = {len_q[3:0], dig.value};
						else if (cnt_q < ADDR_END)
							raddr_d = {raddr_q[ADDR_BITS-5:0], dig.value};
						else
							kind_d = kind_new;
						cnt_d = cnt_q + 4'd1;
						if (cnt_q == HDR_NIBBLES - 4'd1) begin
							idx_d   = 8'd0;
							half_d  = 1'b0;
							bad_d   = 1'b0;
							phase_d = (kind_new == KIND_DATA && len_q != 8'd0)
								? PH_DATA : PH_SKIP;
						end
					end
				end
				PH_DATA: begin
					if (!half_q) begin
						bad_d  = dig.bad;
						pend_d = dig.value;
						half_d = 1'b1;
					end else begin
						// second digit completes a byte
						half_d   = 1'b0;
						bad_d    = 1'b0;
						wr.valid = 1'b1;
						idx_d    = idx_inc;
						if (idx_inc >= len_q)
							phase_d = PH_SKIP;
					end
				end
				default: begin
					phase_d = PH_START;
				end
			endcase
		end
		if (!step && !clear) begin
			wr.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q   <= 4'd0;
			len_q   <= 8'd0;
			raddr_q <= '0;
			kind_q  <= 8'd0;
			idx_q   <= 8'd0;
			pend_q  <= 4'd0;
			half_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else if (step || clear) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			raddr_q <= raddr_d;
			kind_q  <= kind_d;
			idx_q   <= idx_d;
			pend_q  <= pend_d;
			half_q  <= half_d;
			bad_q   <= bad_d;
		end
	end

endmodule

// File: design/ihex_extent.sv
// Running lowest and highest written address
module ihex_extent (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  ihex_pkg::wr_beat_t wr,
	output ihex_pkg::addr_t    low_next,
	output ihex_pkg::addr_t    high_next
);
	import ihex_pkg::*;

	addr_t low_q;
	addr_t high_q;
	logic  valid_q;

	// New extents including the current write
	always_comb begin
		low_next  = low_q;
		high_next = high_q;
		if (wr.valid) begin
			if (!valid_q || wr.addr < low_q)
				low_next = wr.addr;
			if (!valid_q || wr.addr > high_q)
				high_next = wr.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			high_q  <= '0;
			valid_q <= 1'b0;
		end else if (clear) begin
			low_q   <= '0;
			high_q  <= '0;
			valid_q <= 1'b0;
		end else if (wr.valid) begin
			low_q   <= low_next;
			high_q  <= high_next;
			valid_q <= 1'b1;
		end
	end

endmodule

// File: design/intel_hex_record_parser_core.sv
// Channel | Dir | Beat payload
// text    | in  | mode, char_code
// wr      | out | write_addr, write_data, lowest_addr, highest_addr
//
// One character beat per cycle unless the output stalls: an input register feeds the line
// state machine and extent compare, whose write beat lands in the output register.
// Reset returns the parser to line start and clears the extents.
// A stalled output register holds the input register; text.ready drops
// only while both are full and wr.ready is low.
module intel_hex_record_parser_core (
	input  logic      clk,
	input  logic      arst_n,
	ihex_text_if.sink text,
	ihex_wr_if.source wr
);
	import ihex_pkg::*;

	logic     valid_s1;
	logic     mode_s1;
	byte_t    char_s1;
	logic     advance;
	logic     out_valid_q;
	addr_t    addr_q;
	byte_t    data_q;
	addr_t    low_q;
	addr_t    high_q;
	wr_beat_t beat;
	addr_t    low_next;
	addr_t    high_next;

	assign advance    = valid_s1 && (!out_valid_q || wr.ready);
	assign text.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			mode_s1 <= text.mode;
			char_s1 <= text.char_code;
		end
	end

	ihex_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance && mode_s1 == MODE_CHAR),
		.clear     (advance && mode_s1 == MODE_START),
		.char_code (char_s1),
		.wr        (beat)
	);

	ihex_extent u_extent (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (advance && mode_s1 == MODE_START),
		.wr        (beat),
		.low_next  (low_next),
		.high_next (high_next)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= beat.valid;
		end else if (wr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat.valid) begin
			addr_q <= beat.addr;
			data_q <= beat.data;
			low_q  <= low_next;
			high_q <= high_next;
		end
	end

	assign wr.valid        = out_valid_q;
	assign wr.write_addr   = addr_q;
	assign wr.write_data   = data_q;
	assign wr.lowest_addr  = low_q;
	assign wr.highest_addr = high_q;

endmodule
